// ----- design/pdt_pkg.sv -----
// Shared constants, types and helpers for the palette dictionary table.
`default_nettype none

package pdt_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ID_BITS     = 16;

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  // Fixed payload widths
  localparam int CMD_W    = 2;
  localparam int SID_W    = 16;
  localparam int IDX_W    = 12;
  localparam int CNT_FW   = 13;
  localparam int BPB_W    = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET_ADD = 2'd0,
    CMD_LOOKUP  = 2'd1,
    CMD_READ    = 2'd2,
    CMD_CLEAR   = 2'd3
  } pdt_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_DONE
  } pdt_state_e;

  typedef struct packed {
    logic load;        // input transfer: capture payload
    logic add_sel;     // with load: command may append
    logic clear;       // with load: reinit table
    logic read_issue;  // with load: read entry at local index
    logic scan;        // walk one entry
    logic finish_scan; // resolve search result
    logic finish_read; // resolve read result
    logic push;        // move result to output register
  } pdt_ctrl_t;

  typedef struct packed {
    logic scan_hit;
    logic scan_end;
    logic out_free;
  } pdt_stat_t;

  function automatic logic [ID_BITS-1:0] to_id(input logic [SID_W-1:0] v);
    logic [ID_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < ID_BITS; i++) begin
      if (i < SID_W) r[i] = v[i];
    end
    return r;
  endfunction

  function automatic logic [SID_W-1:0] from_id(input logic [ID_BITS-1:0] v);
    logic [SID_W-1:0] r;
    r = '0;
    for (int i = 0; i < SID_W; i++) begin
      if (i < ID_BITS) r[i] = v[i];
    end
    return r;
  endfunction

  function automatic logic [BPB_W-1:0] tier(input logic [CNT_FW-1:0] n);
    logic [BPB_W-1:0] r;
    if (n <= CNT_FW'(1)) r = BPB_W'(1);
    else if (n <= CNT_FW'(16)) r = BPB_W'(4);
    else if (n <= CNT_FW'(256)) r = BPB_W'(8);
    else r = BPB_W'(12);
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/pdt_if.sv -----
// Valid/ready channel interfaces for commands and results.
`default_nettype none

interface pdt_in_if
  import pdt_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [SID_W-1:0] state_id;
  logic [IDX_W-1:0] local_index;

  modport source (output valid, command, state_id, local_index, input ready);
  modport sink   (input valid, command, state_id, local_index, output ready);
endinterface

interface pdt_out_if
  import pdt_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index_out;
  logic [SID_W-1:0]  id_out;
  logic              found;
  logic              overflow;
  logic [CNT_FW-1:0] entry_count;
  logic [BPB_W-1:0]  bits_per_block;

  modport source (output valid, index_out, id_out, found, overflow, entry_count,
                  bits_per_block, input ready);
  modport sink   (input valid, index_out, id_out, found, overflow, entry_count,
                  bits_per_block, output ready);
endinterface

`default_nettype wire

// ----- design/pdt_ctrl.sv -----
// Controller state machine: sequences accept, scan, read and result transfer.
`default_nettype none

module pdt_ctrl
  import pdt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic [CMD_W-1:0] in_command_i,
  output logic                  in_ready_o,
  input  wire pdt_stat_t        stat_i,
  output pdt_ctrl_t             ctrl_o
);

  pdt_state_e state_q, state_d;
  pdt_cmd_e   cmd;

  assign cmd = pdt_cmd_e'(in_command_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (cmd)
            CMD_GET_ADD: state_d = ST_SCAN;
            CMD_LOOKUP:  state_d = ST_SCAN;
            CMD_READ:    state_d = ST_READ;
            CMD_CLEAR:   state_d = ST_DONE;
            default:     state_d = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (stat_i.scan_hit || stat_i.scan_end) state_d = ST_DONE;
      end
      ST_READ: state_d = ST_DONE;
      ST_DONE: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o         = (state_q == ST_IDLE);
    ctrl_o             = '0;
    ctrl_o.load        = (state_q == ST_IDLE) && in_valid_i;
    ctrl_o.add_sel     = (cmd == CMD_GET_ADD);
    ctrl_o.clear       = ctrl_o.load && (cmd == CMD_CLEAR);
    ctrl_o.read_issue  = ctrl_o.load && (cmd == CMD_READ);
    ctrl_o.scan        = (state_q == ST_SCAN);
    ctrl_o.finish_scan = (state_q == ST_SCAN) && (stat_i.scan_hit || stat_i.scan_end);
    ctrl_o.finish_read = (state_q == ST_READ);
    ctrl_o.push        = (state_q == ST_DONE) && stat_i.out_free;
  end

endmodule

`default_nettype wire

// ----- design/pdt_datapath.sv -----
// Datapath: entry memory, count, search pipeline, result and output registers.
`default_nettype none

module pdt_datapath
  import pdt_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [SID_W-1:0]  cfg_wdata_i,
  input  wire logic [SID_W-1:0]  in_state_id_i,
  input  wire logic [IDX_W-1:0]  in_local_index_i,
  input  wire pdt_ctrl_t         ctrl_i,
  output pdt_stat_t              stat_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic [IDX_W-1:0]       out_index_o,
  output logic [SID_W-1:0]       out_id_o,
  output logic                   out_found_o,
  output logic                   out_overflow_o,
  output logic [CNT_FW-1:0]      out_count_o,
  output logic [BPB_W-1:0]       out_bpb_o
);

  logic [ID_BITS-1:0] mem [TABLE_DEPTH];

  logic [SID_W-1:0]   air_q;
  logic [ID_BITS-1:0] entry0_q;
  logic [CNT_W-1:0]   count_q;
  logic               add_q;
  logic [ID_BITS-1:0] sid_q;
  logic [IDX_W-1:0]   lidx_q;
  logic [CNT_W-1:0]   ptr_q;
  logic               cmp_v_q;
  logic [ADDR_W-1:0]  cmp_idx_q;
  logic [ID_BITS-1:0] rd_q;

  logic [IDX_W-1:0]   res_idx_q;
  logic [SID_W-1:0]   res_id_q;
  logic               res_fnd_q;
  logic               res_ovf_q;

  logic               out_vld_q;
  logic [IDX_W-1:0]   out_idx_q;
  logic [SID_W-1:0]   out_id_q;
  logic               out_fnd_q;
  logic               out_ovf_q;
  logic [CNT_FW-1:0]  out_cnt_q;
  logic [BPB_W-1:0]   out_bpb_q;

  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               scan_rd;
  logic [ID_BITS-1:0] cmp_data;
  logic               match;
  logic               last;
  logic               full;
  logic               wr_en;
  logic               lidx_ok;
  logic [ID_BITS-1:0] lidx_data;

  assign scan_rd  = ctrl_i.scan && (ptr_q < count_q);
  assign rd_en    = scan_rd || ctrl_i.read_issue;
  assign rd_addr  = ctrl_i.read_issue ? in_local_index_i[ADDR_W-1:0] : ptr_q[ADDR_W-1:0];

  // Entry zero lives in a register; the memory copy of it is never used
  assign cmp_data = (cmp_idx_q == '0) ? entry0_q : rd_q;
  assign match    = cmp_v_q && (cmp_data == sid_q);
  assign last     = cmp_v_q && (CNT_W'(cmp_idx_q) == count_q - CNT_W'(1));
  assign full     = (count_q == CNT_W'(TABLE_DEPTH));
  assign wr_en    = ctrl_i.finish_scan && !match && add_q && !full;

  assign lidx_ok   = {1'b0, lidx_q} < CNT_FW'(count_q);
  assign lidx_data = (lidx_q == '0) ? entry0_q : rd_q;

  assign stat_o.scan_hit = match;
  assign stat_o.scan_end = last;
  assign stat_o.out_free = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[ADDR_W-1:0]] <= sid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      air_q    <= '0;
      entry0_q <= '0;
      count_q  <= CNT_W'(1);
      cmp_v_q  <= 1'b0;
    end else begin
      if (cfg_we_i) air_q <= cfg_wdata_i;
      if (ctrl_i.clear) begin
        entry0_q <= to_id(air_q);
        count_q  <= CNT_W'(1);
      end else if (wr_en) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (ctrl_i.load) cmp_v_q <= 1'b0;
      else if (ctrl_i.scan) cmp_v_q <= scan_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      add_q  <= ctrl_i.add_sel;
      sid_q  <= to_id(in_state_id_i);
      lidx_q <= in_local_index_i;
      ptr_q  <= '0;
    end else if (scan_rd) begin
      ptr_q     <= ptr_q + CNT_W'(1);
      cmp_idx_q <= ptr_q[ADDR_W-1:0];
    end
  end

  // Resolve the result of the current command
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      res_idx_q <= '0;
      res_id_q  <= from_id(to_id(air_q));
      res_fnd_q <= 1'b1;
      res_ovf_q <= 1'b0;
    end else if (ctrl_i.finish_read) begin
      res_idx_q <= lidx_q;
      res_id_q  <= lidx_ok ? from_id(lidx_data) : air_q;
      res_fnd_q <= lidx_ok;
      res_ovf_q <= 1'b0;
    end else if (ctrl_i.finish_scan) begin
      if (match) begin
        res_idx_q <= IDX_W'(cmp_idx_q);
        res_id_q  <= from_id(sid_q);
        res_fnd_q <= 1'b1;
        res_ovf_q <= 1'b0;
      end else if (wr_en) begin
        res_idx_q <= IDX_W'(count_q);
        res_id_q  <= from_id(sid_q);
        res_fnd_q <= 1'b1;
        res_ovf_q <= 1'b0;
      end else begin
        res_idx_q <= '0;
        res_id_q  <= '0;
        res_fnd_q <= 1'b0;
        res_ovf_q <= add_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctrl_i.push) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      out_idx_q <= res_idx_q;
      out_id_q  <= res_id_q;
      out_fnd_q <= res_fnd_q;
      out_ovf_q <= res_ovf_q;
      out_cnt_q <= CNT_FW'(count_q);
      out_bpb_q <= tier(CNT_FW'(count_q));
    end
  end

  assign out_valid_o    = out_vld_q;
  assign out_index_o    = out_idx_q;
  assign out_id_o       = out_id_q;
  assign out_found_o    = out_fnd_q;
  assign out_overflow_o = out_ovf_q;
  assign out_count_o    = out_cnt_q;
  assign out_bpb_o      = out_bpb_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) && (count_q <= CNT_W'(TABLE_DEPTH)))
    else $error("entry count out of range");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push |-> (!out_vld_q || out_ready_i))
    else $error("result pushed over a pending transfer");

  a_append_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (count_q == $past(count_q) + 1))
    else $error("append did not advance the count");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !wr_en)
    else $error("append into a full table");

endmodule

`default_nettype wire

// ----- design/palette_dictionary_table_core.sv -----
// Get-or-add / lookup: the result is bounded by the entry search that reads one stored entry
// per cycle, ending at the matching entry on a hit or at the last entry on a miss.
// Read by index uses one memory read. A stalled output delays the result.
// One command is in flight at a time; the next input transfer is taken at the clock edge
// after the result enters the output register.
// Reset: table holds a single entry (id 0), air id register 0, no result pending.
`default_nettype none

module palette_dictionary_table_core
  import pdt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [SID_W-1:0] cfg_wdata_i,
  pdt_in_if.sink                in_i,
  pdt_out_if.source             out_o
);

  pdt_ctrl_t ctrl;
  pdt_stat_t stat;

  pdt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_ready_o   (in_i.ready),
    .stat_i       (stat),
    .ctrl_o       (ctrl)
  );

  pdt_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_state_id_i    (in_i.state_id),
    .in_local_index_i (in_i.local_index),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .out_index_o      (out_o.index_out),
    .out_id_o         (out_o.id_out),
    .out_found_o      (out_o.found),
    .out_overflow_o   (out_o.overflow),
    .out_count_o      (out_o.entry_count),
    .out_bpb_o        (out_o.bits_per_block)
  );

endmodule

`default_nettype wire

// ----- sim/palette_dictionary_table_core_test.sv -----
// Self-checking testbench for the palette dictionary table core.
`timescale 1ns / 100ps

module palette_dictionary_table_core_test;
  import pdt_pkg::*;

  localparam int RESET_CYCLES = 9;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 32;
  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_ITEMS = 30;

  typedef enum logic [1:0] {
    STEP_CMD,
    STEP_CFG,
    STEP_SYNC
  } step_kind_e;

  typedef struct {
    step_kind_e       kind;
    pdt_cmd_e         command;
    logic [SID_W-1:0] state_id;
    logic [IDX_W-1:0] local_index;
    bit               steady;
  } palette_step_t;

  typedef struct packed {
    logic [IDX_W-1:0]  index_out;
    logic [SID_W-1:0]  id_out;
    logic              found;
    logic              overflow;
    logic [CNT_FW-1:0] entry_count;
    logic [BPB_W-1:0]  bits_per_block;
  } palette_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [SID_W-1:0] cfg_wdata = '0;

  pdt_in_if  in_bus ();
  pdt_out_if out_bus ();

  palette_dictionary_table_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  always #1 clk_i = ~clk_i;

  // Shadow of the dictionary
  logic [ID_BITS-1:0] shadow_ids [TABLE_DEPTH];
  int unsigned        shadow_count = 1;
  logic [SID_W-1:0]   shadow_air = '0;

  palette_step_t   step_backlog [$];
  palette_result_t replies_due [$];
  int unsigned     mismatch_count = 0;
  int unsigned     cycle_count = 0;

  int burst_left = 0;
  int gap_left = 0;
  int settle_cnt = 0;

  int ready_mode = 0;
  int mode_left = 0;
  int unsigned ready_beat = 0;

  function automatic palette_result_t palette_predict(input pdt_cmd_e op,
                                                      input logic [SID_W-1:0] sid,
                                                      input logic [IDX_W-1:0] idx);
    palette_result_t r;
    int hit;
    int unsigned i;
    r = '0;
    hit = -1;
    case (op)
      CMD_GET_ADD, CMD_LOOKUP: begin
        i = 0;
        while (i < shadow_count && hit < 0) begin
          if (shadow_ids[i] == ID_BITS'(sid)) hit = i;
          i++;
        end
        if (hit >= 0) begin
          r.index_out = IDX_W'(hit);
          r.id_out = sid;
          r.found = 1'b1;
        end else if (op == CMD_GET_ADD) begin
          if (shadow_count >= TABLE_DEPTH) begin
            r.overflow = 1'b1;
          end else begin
            shadow_ids[shadow_count] = ID_BITS'(sid);
            r.index_out = IDX_W'(shadow_count);
            r.id_out = sid;
            r.found = 1'b1;
            shadow_count++;
          end
        end
      end
      CMD_READ: begin
        r.index_out = idx;
        if (idx < shadow_count) begin
          r.id_out = SID_W'(shadow_ids[idx]);
          r.found = 1'b1;
        end else begin
          r.id_out = shadow_air;
        end
      end
      default: begin
        shadow_ids[0] = ID_BITS'(shadow_air);
        shadow_count = 1;
        r.id_out = shadow_air;
        r.found = 1'b1;
      end
    endcase
    r.entry_count = CNT_FW'(shadow_count);
    if (shadow_count <= 1) r.bits_per_block = 4'd1;
    else if (shadow_count <= 16) r.bits_per_block = 4'd4;
    else if (shadow_count <= 256) r.bits_per_block = 4'd8;
    else r.bits_per_block = 4'd12;
    return r;
  endfunction

  task automatic queue_command(input pdt_cmd_e op, input logic [SID_W-1:0] sid,
                               input logic [IDX_W-1:0] idx, input bit steady);
    palette_step_t s;
    s.kind = STEP_CMD;
    s.command = op;
    s.state_id = sid;
    s.local_index = idx;
    s.steady = steady;
    step_backlog = {step_backlog, s};
  endtask

  task automatic queue_config(input logic [SID_W-1:0] air);
    palette_step_t s;
    s.kind = STEP_CFG;
    s.command = CMD_CLEAR;
    s.state_id = air;
    s.local_index = '0;
    s.steady = 1'b0;
    step_backlog = {step_backlog, s};
  endtask

  task automatic queue_pause();
    palette_step_t s;
    s.kind = STEP_SYNC;
    s.command = CMD_CLEAR;
    s.state_id = '0;
    s.local_index = '0;
    s.steady = 1'b0;
    step_backlog = {step_backlog, s};
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  // Command driver: bursts with random gaps, config writes only when idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      in_bus.command <= CMD_GET_ADD;
      in_bus.state_id <= '0;
      in_bus.local_index <= '0;
      cfg_we <= 1'b0;
      cfg_wdata <= '0;
    end else begin : drive
      palette_step_t head;
      logic nxt_valid;
      logic nxt_we;
      nxt_valid = in_bus.valid;
      nxt_we = 1'b0;
      if (in_bus.valid && in_bus.ready) begin
        replies_due = {replies_due, palette_predict(pdt_cmd_e'(in_bus.command),
                                                    in_bus.state_id, in_bus.local_index)};
        nxt_valid = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (!nxt_valid && step_backlog.size() > 0) begin
        head = step_backlog[0];
        case (head.kind)
          STEP_CMD: begin
            if (gap_left > 0 && !head.steady) begin
              gap_left--;
            end else begin
              void'(step_backlog.pop_front());
              nxt_valid = 1'b1;
              in_bus.command <= head.command;
              in_bus.state_id <= head.state_id;
              in_bus.local_index <= head.local_index;
            end
          end
          STEP_CFG: begin
            if (replies_due.size() == 0 && !in_bus.valid) begin
              if (settle_cnt < SETTLE_CYCLES) begin
                settle_cnt++;
              end else begin
                settle_cnt = 0;
                nxt_we = 1'b1;
                cfg_wdata <= head.state_id;
                shadow_air = head.state_id;
                void'(step_backlog.pop_front());
              end
            end
          end
          default: begin
            // hold off until every outstanding reply is back
            if (replies_due.size() == 0 && !in_bus.valid) void'(step_backlog.pop_front());
          end
        endcase
      end
      in_bus.valid <= nxt_valid;
      cfg_we <= nxt_we;
    end
  end

  // Reply monitor with its own stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin : watch
      palette_result_t want;
      logic nxt_ready;
      if (out_bus.valid && out_bus.ready) begin
        if (replies_due.size() == 0) begin
          $error("reply transfer with nothing outstanding");
          mismatch_count++;
        end else begin
          want = replies_due.pop_front();
          check_field("index_out", want.index_out, out_bus.index_out);
          check_field("id_out", want.id_out, out_bus.id_out);
          check_field("found", want.found, out_bus.found);
          check_field("overflow", want.overflow, out_bus.overflow);
          check_field("entry_count", want.entry_count, out_bus.entry_count);
          check_field("bits_per_block", want.bits_per_block, out_bus.bits_per_block);
        end
      end
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      ready_beat++;
      case (ready_mode)
        0: nxt_ready = 1'b1;
        1: nxt_ready = 1'($urandom_range(0, 1));
        2: nxt_ready = (ready_beat[1:0] == 2'd0);
        default: nxt_ready = ($urandom_range(0, 7) != 0);
      endcase
      out_bus.ready <= nxt_ready;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    int phase;
    int n;
    int r;
    int pool_size;
    logic [SID_W-1:0] air_val;
    logic [SID_W-1:0] pool [$];

    in_bus.valid = 1'b0;
    in_bus.command = CMD_GET_ADD;
    in_bus.state_id = '0;
    in_bus.local_index = '0;
    out_bus.ready = 1'b0;
    shadow_ids[0] = '0;

    // Reset state: single entry holding id zero
    queue_command(CMD_READ, 16'h0000, 12'd0, 1'b0);
    queue_command(CMD_LOOKUP, 16'h0000, 12'd0, 1'b0);
    queue_command(CMD_GET_ADD, 16'h0000, 12'd0, 1'b0);
    queue_command(CMD_READ, 16'h0000, 12'd4095, 1'b0);
    // New air id: entry zero untouched, out-of-range reads see it at once
    queue_config(16'hFFFF);
    queue_command(CMD_READ, 16'hFFFF, 12'd0, 1'b0);
    queue_command(CMD_READ, 16'h0000, 12'd1, 1'b0);
    queue_command(CMD_CLEAR, 16'h0000, 12'd0, 1'b0);
    queue_command(CMD_GET_ADD, 16'hFFFF, 12'hFFF, 1'b0);
    queue_command(CMD_GET_ADD, 16'h0000, 12'd0, 1'b0);
    queue_command(CMD_GET_ADD, 16'h5A5A, 12'd0, 1'b0);
    queue_command(CMD_LOOKUP, 16'h5A5A, 12'd0, 1'b0);
    queue_command(CMD_LOOKUP, 16'hA5A5, 12'd0, 1'b0);
    queue_command(CMD_GET_ADD, 16'hA5A5, 12'd0, 1'b0);
    queue_command(CMD_READ, 16'h0000, 12'd3, 1'b0);
    queue_command(CMD_READ, 16'h0000, 12'd4, 1'b0);
    queue_command(CMD_READ, 16'h0000, 12'd4095, 1'b0);
    queue_command(CMD_CLEAR, 16'hFFFF, 12'hFFF, 1'b0);
    queue_command(CMD_LOOKUP, 16'h0000, 12'd0, 1'b0);

    // Random phases: ids drawn from a small pool so hits and tiers both occur
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      air_val = (phase == 0) ? 16'h0000 : 16'($urandom_range(0, 65535));
      queue_config(air_val);
      // leave one phase with a stale entry zero
      if (phase != 2) queue_command(CMD_CLEAR, 16'($urandom), 12'($urandom), 1'b0);
      pool_size = (phase == 0) ? 4 : (phase == 1) ? 12 : (phase == 2) ? 30 : 40;
      pool.delete();
      pool = {pool, air_val};
      for (n = 1; n < pool_size; n++) pool = {pool, 16'($urandom_range(0, 65535))};
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) queue_pause();
        r = $urandom_range(0, 99);
        if (r < 45)
          queue_command(CMD_GET_ADD, pool[$urandom_range(0, pool.size() - 1)],
                        12'($urandom), 1'b0);
        else if (r < 65)
          queue_command(CMD_LOOKUP, pool[$urandom_range(0, pool.size() - 1)],
                        12'($urandom), 1'b0);
        else if (r < 85)
          queue_command(CMD_READ, 16'($urandom),
                        12'($urandom_range(0, pool_size + 2)), 1'b0);
        else if (r < 89)
          queue_command(CMD_CLEAR, 16'($urandom), 12'($urandom), 1'b0);
        else
          queue_command(pdt_cmd_e'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                        12'($urandom_range(0, 4095)), 1'b0);
      end
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (step_backlog.size() != 0 || in_bus.valid || replies_due.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && replies_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/pdt_pkg.sv
design/pdt_if.sv
design/pdt_ctrl.sv
design/pdt_datapath.sv
design/palette_dictionary_table_core.sv
sim/palette_dictionary_table_core_test.sv
